@@ hw/rtl/fixed_point_dda_line_drawer_defines.svh @@
// Assertion macros shared by the RTL.
`ifndef FIXED_POINT_DDA_LINE_DRAWER_DEFINES_SVH
`define FIXED_POINT_DDA_LINE_DRAWER_DEFINES_SVH

`ifndef SYNTH
`define FPDDA_ASSERT(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("fpdda assertion failed");
`define FPDDA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fpdda implication failed");
`else
`define FPDDA_ASSERT(label, clk, rst_n, expr)
`define FPDDA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`endif

`endif

@@ hw/rtl/fpdda_pkg.sv @@
package fpdda_pkg;

  localparam int COORD_BITS  = 12;
  localparam int FRAC_BITS   = 16;
  localparam int CFG_BITS    = 13;
  localparam int CFG_IDX_BITS = 2;
  localparam int COLOUR_BITS = 8;
  localparam int STEP_BITS   = FRAC_BITS + 2;
  localparam int ACC_BITS    = COORD_BITS + FRAC_BITS + 2;
  localparam int LEFT_BITS   = COORD_BITS + 1;
  localparam int CMDQ_DEPTH  = 2;

  localparam logic [CFG_BITS-1:0] SCREEN_WIDTH_RST  = CFG_BITS'(640);
  localparam logic [CFG_BITS-1:0] SCREEN_HEIGHT_RST = CFG_BITS'(480);

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_WIDTH  = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_HEIGHT = CFG_IDX_BITS'(1);

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_VERT,
    MODE_HORZ,
    MODE_XMAJ,
    MODE_YMAJ
  } mode_t;

  typedef struct packed {
    logic                   is_start;
    mode_t                  mode;
    logic [COORD_BITS-1:0]  origin_x;
    logic [COORD_BITS-1:0]  origin_y;
    logic                   x_dir;
    logic                   y_dir;
    logic [LEFT_BITS-1:0]   pixels_left;
    logic [STEP_BITS-1:0]   minor_step;
    logic [COLOUR_BITS-1:0] colour;
  } cmd_t;

endpackage

@@ hw/rtl/fpdda_front.sv @@
`include "fixed_point_dda_line_drawer_defines.svh"

module fpdda_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_push,
  output logic                             in_full,
  input  logic                             in_opcode,
  input  logic [fpdda_pkg::COORD_BITS-1:0]  in_from_x,
  input  logic [fpdda_pkg::COORD_BITS-1:0]  in_from_y,
  input  logic [fpdda_pkg::COORD_BITS-1:0]  in_to_x,
  input  logic [fpdda_pkg::COORD_BITS-1:0]  in_to_y,
  input  logic [fpdda_pkg::COLOUR_BITS-1:0] in_ink,
  output logic                             q_push,
  output fpdda_pkg::cmd_t                  q_cmd,
  input  logic                             q_full
);
  import fpdda_pkg::*;

  localparam int CNT_BITS = $clog2(FRAC_BITS + 1);

  typedef enum logic {FR_IDLE, FR_DIV} fr_state_t;

  fr_state_t              state_r;
  cmd_t                   cmd_r;
  logic [COORD_BITS-1:0]  major_r;
  logic [COORD_BITS-1:0]  rem_r;
  logic [FRAC_BITS:0]     quo_r;
  logic [CNT_BITS-1:0]    cnt_r;
  logic                   neg_r;

  logic [COORD_BITS:0]    dx, dy, mag_x, mag_y;
  logic [COORD_BITS-1:0]  adx, ady, major, minor;
  logic                   sloped, minor_neg, accept;
  cmd_t                   cmd_c;
  logic [COORD_BITS:0]    rem2;
  logic                   ge;
  logic [STEP_BITS-1:0]   quo_ext;

  always_comb begin
    dx    = {1'b0, in_to_x} - {1'b0, in_from_x};
    dy    = {1'b0, in_to_y} - {1'b0, in_from_y};
    mag_x = dx[COORD_BITS] ? (~dx + 1'b1) : dx;
    mag_y = dy[COORD_BITS] ? (~dy + 1'b1) : dy;
    adx   = mag_x[COORD_BITS-1:0];
    ady   = mag_y[COORD_BITS-1:0];
    major = (adx >= ady) ? adx : ady;
    minor = (adx >= ady) ? ady : adx;
    minor_neg = (adx >= ady) ? dy[COORD_BITS] : dx[COORD_BITS];
    sloped = (adx != '0) && (ady != '0);

    cmd_c             = '0;
    cmd_c.is_start    = (in_opcode == OP_START);
    cmd_c.origin_x    = in_from_x;
    cmd_c.origin_y    = in_from_y;
    cmd_c.x_dir       = dx[COORD_BITS];
    cmd_c.y_dir       = dy[COORD_BITS];
    cmd_c.colour      = in_ink;
    cmd_c.pixels_left = {1'b0, major};
    priority if (adx == '0 && ady == '0) begin
      cmd_c.mode = MODE_IDLE;
    end else if (adx == '0) begin
      cmd_c.mode = MODE_VERT;
    end else if (ady == '0) begin
      cmd_c.mode = MODE_HORZ;
    end else if (adx >= ady) begin
      cmd_c.mode = MODE_XMAJ;
    end else begin
      cmd_c.mode = MODE_YMAJ;
    end
  end

  assign in_full = (state_r != FR_IDLE) || q_full;
  assign accept  = in_push && !in_full;

  always_comb begin
    rem2    = {rem_r, 1'b0};
    ge      = rem2 >= {1'b0, major_r};
    quo_ext = {1'b0, quo_r};
  end

  always_comb begin
    q_push = 1'b0;
    q_cmd  = cmd_c;
    unique case (state_r)
      FR_IDLE: begin
        q_push = accept && !(cmd_c.is_start && sloped);
      end
      FR_DIV: begin
        q_push           = (cnt_r == '0) && !q_full;
        q_cmd            = cmd_r;
        q_cmd.minor_step = neg_r ? (~quo_ext + 1'b1) : quo_ext;
      end
      default: begin
        q_push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FR_IDLE;
    end else begin
      unique case (state_r)
        FR_IDLE: begin
          if (accept && cmd_c.is_start && sloped) begin
            state_r <= FR_DIV;
            cmd_r   <= cmd_c;
            major_r <= major;
            neg_r   <= minor_neg;
            cnt_r   <= CNT_BITS'(FRAC_BITS);
            rem_r   <= (minor == major) ? '0 : minor;
            quo_r   <= (FRAC_BITS + 1)'(minor == major);
          end
        end
        FR_DIV: begin
          if (cnt_r != '0) begin
            cnt_r <= cnt_r - 1'b1;
            rem_r <= ge ? COORD_BITS'(rem2 - {1'b0, major_r}) : rem2[COORD_BITS-1:0];
            quo_r <= {quo_r[FRAC_BITS-1:0], ge};
          end else if (!q_full) begin
            state_r <= FR_IDLE;
          end
        end
        default: begin
          state_r <= FR_IDLE;
        end
      endcase
    end
  end

  `FPDDA_ASSERT_IMP(a_rem_below_div, clk, rst_n, state_r == FR_DIV, rem_r < major_r)
  `FPDDA_ASSERT_IMP(a_div_no_accept, clk, rst_n, state_r == FR_DIV, !accept)

endmodule

@@ hw/rtl/fpdda_cmdq.sv @@
`include "fixed_point_dda_line_drawer_defines.svh"

module fpdda_cmdq #(
  parameter int DEPTH = fpdda_pkg::CMDQ_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  fpdda_pkg::cmd_t push_cmd,
  output logic            full,
  output logic            valid,
  output fpdda_pkg::cmd_t pop_cmd,
  input  logic            pop
);
  import fpdda_pkg::*;

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  cmd_t                mem [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_BITS-1:0] cnt_r;
  logic                do_push, do_pop;

  assign full    = (cnt_r == CNT_BITS'(DEPTH));
  assign valid   = (cnt_r != '0);
  assign pop_cmd = mem[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  `FPDDA_ASSERT(a_cnt_range, clk, rst_n, cnt_r <= CNT_BITS'(DEPTH))

endmodule

@@ hw/rtl/fpdda_back.sv @@
`include "fixed_point_dda_line_drawer_defines.svh"

module fpdda_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             q_valid,
  input  fpdda_pkg::cmd_t                  q_cmd,
  output logic                             q_pop,
  input  logic [fpdda_pkg::CFG_BITS-1:0]    screen_width,
  input  logic [fpdda_pkg::CFG_BITS-1:0]    screen_height,
  output logic                             out_empty,
  input  logic                             out_pop,
  output logic [fpdda_pkg::COORD_BITS-1:0]  out_pixel_x,
  output logic [fpdda_pkg::COORD_BITS-1:0]  out_pixel_y,
  output logic [fpdda_pkg::COLOUR_BITS-1:0] out_pixel_colour,
  output logic                             out_visible,
  output logic                             out_last
);
  import fpdda_pkg::*;

  mode_t                  mode_r;
  logic [COORD_BITS-1:0]  origin_x_r, origin_y_r, cur_x_r, cur_y_r;
  logic [STEP_BITS-1:0]   step_r;
  logic [ACC_BITS-1:0]    acc_r;
  logic                   x_dir_r, y_dir_r;
  logic [LEFT_BITS-1:0]   left_r;
  logic [COLOUR_BITS-1:0] colour_r;
  logic                   out_valid_r;
  logic [COORD_BITS-1:0]  out_pixel_x_r, out_pixel_y_r;
  logic [COLOUR_BITS-1:0] out_pixel_colour_r;
  logic                   out_visible_r, out_last_r;

  logic                   active, emit, minor_is_x;
  logic [ACC_BITS-1:0]    acc_nxt;
  logic [COORD_BITS-1:0]  minor_nxt, cur_x_stepped, cur_y_stepped;

  assign out_empty = !out_valid_r;
  assign q_pop     = q_valid && (!out_valid_r || out_pop);
  assign active    = (mode_r != MODE_IDLE) && (left_r != '0);
  assign emit      = q_pop && !q_cmd.is_start && active;
  assign minor_is_x = (mode_r == MODE_VERT) || (mode_r == MODE_YMAJ);

  assign out_pixel_x      = out_pixel_x_r;
  assign out_pixel_y      = out_pixel_y_r;
  assign out_pixel_colour = out_pixel_colour_r;
  assign out_visible      = out_visible_r;
  assign out_last         = out_last_r;

  always_comb begin
    acc_nxt = acc_r + {{(ACC_BITS - STEP_BITS){step_r[STEP_BITS-1]}}, step_r};
    minor_nxt = (minor_is_x ? origin_x_r : origin_y_r) + acc_nxt[FRAC_BITS +: COORD_BITS];
    cur_x_stepped = x_dir_r ? cur_x_r - 1'b1 : cur_x_r + 1'b1;
    cur_y_stepped = y_dir_r ? cur_y_r - 1'b1 : cur_y_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_pop && out_valid_r) begin
        out_valid_r <= 1'b0;
      end
      if (q_pop) begin
        if (q_cmd.is_start) begin
          mode_r     <= q_cmd.mode;
          origin_x_r <= q_cmd.origin_x;
          origin_y_r <= q_cmd.origin_y;
          cur_x_r    <= q_cmd.origin_x;
          cur_y_r    <= q_cmd.origin_y;
          x_dir_r    <= q_cmd.x_dir;
          y_dir_r    <= q_cmd.y_dir;
          left_r     <= q_cmd.pixels_left;
          step_r     <= q_cmd.minor_step;
          acc_r      <= '0;
          colour_r   <= q_cmd.colour;
        end else if (!active) begin
          mode_r <= MODE_IDLE;
        end else begin
          out_pixel_x_r      <= cur_x_r;
          out_pixel_y_r      <= cur_y_r;
          out_pixel_colour_r <= colour_r;
          out_visible_r      <= ({1'b0, cur_x_r} < screen_width) &&
                                ({1'b0, cur_y_r} < screen_height);
          out_last_r         <= (left_r == LEFT_BITS'(1));
          left_r             <= left_r - 1'b1;
          acc_r              <= acc_nxt;
          if (minor_is_x) begin
            cur_y_r <= cur_y_stepped;
            cur_x_r <= minor_nxt;
          end else begin
            cur_x_r <= cur_x_stepped;
            cur_y_r <= minor_nxt;
          end
          if (left_r == LEFT_BITS'(1)) begin
            mode_r <= MODE_IDLE;
          end
        end
      end
    end
  end

  `FPDDA_ASSERT_IMP(a_active_has_left, clk, rst_n, mode_r != MODE_IDLE, left_r != '0)
  `FPDDA_ASSERT_IMP(a_emit_has_room, clk, rst_n, emit, !out_valid_r || out_pop)

endmodule

@@ hw/rtl/fixed_point_dda_line_drawer.sv @@
// Fixed-point DDA line rasterizer.
// Input channel (in_push/in_full): opcode 0 loads a line (from, to, ink) and
// gives no pixel; opcode 1 asks for the next pixel of the current line.
// Result channel (out_empty/out_pop): one beat per pixel, with position,
// colour, on-screen flag and a last flag on the final pixel.
// Config channel (cfg_valid/cfg_ready): index 0 screen width, 1 screen height;
// always ready; write only while the block is idle.
// A step beat goes through the queue and output register to the result ports.
// Throughput: one step beat per cycle while out_pop keeps the output drained.
// Axis-aligned and zero-length starts go straight to the queue; a sloping start
// blocks the input while the bit-serial divider forms the minor step.
// A short command queue sits between the front (classify, divide) and the
// back (step, output register), so each side stalls on its own.
// When out_pop is held low the output register holds its beat, the queue
// fills and in_full rises.
// Reset: no line active, screen 640 x 480, queue and output empty.
module fixed_point_dda_line_drawer #(
  parameter int CMDQ_DEPTH = fpdda_pkg::CMDQ_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_push,
  output logic                               in_full,
  input  logic                               in_opcode,
  input  logic [fpdda_pkg::COORD_BITS-1:0]    in_from_x,
  input  logic [fpdda_pkg::COORD_BITS-1:0]    in_from_y,
  input  logic [fpdda_pkg::COORD_BITS-1:0]    in_to_x,
  input  logic [fpdda_pkg::COORD_BITS-1:0]    in_to_y,
  input  logic [fpdda_pkg::COLOUR_BITS-1:0]   in_ink,
  output logic                               out_empty,
  input  logic                               out_pop,
  output logic [fpdda_pkg::COORD_BITS-1:0]    out_pixel_x,
  output logic [fpdda_pkg::COORD_BITS-1:0]    out_pixel_y,
  output logic [fpdda_pkg::COLOUR_BITS-1:0]   out_pixel_colour,
  output logic                               out_visible,
  output logic                               out_last,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [fpdda_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [fpdda_pkg::CFG_BITS-1:0]      cfg_data
);
  import fpdda_pkg::*;

  logic [CFG_BITS-1:0] screen_width_r, screen_height_r;
  logic                fq_push, fq_full, qb_valid, qb_pop;
  cmd_t                fq_cmd, qb_cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_width_r  <= SCREEN_WIDTH_RST;
      screen_height_r <= SCREEN_HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_SCREEN_WIDTH) begin
        screen_width_r <= cfg_data;
      end else if (cfg_index == CFG_SCREEN_HEIGHT) begin
        screen_height_r <= cfg_data;
      end
    end
  end

  fpdda_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_opcode (in_opcode),
    .in_from_x (in_from_x),
    .in_from_y (in_from_y),
    .in_to_x   (in_to_x),
    .in_to_y   (in_to_y),
    .in_ink    (in_ink),
    .q_push    (fq_push),
    .q_cmd     (fq_cmd),
    .q_full    (fq_full)
  );

  fpdda_cmdq #(
    .DEPTH (CMDQ_DEPTH)
  ) u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (fq_push),
    .push_cmd (fq_cmd),
    .full     (fq_full),
    .valid    (qb_valid),
    .pop_cmd  (qb_cmd),
    .pop      (qb_pop)
  );

  fpdda_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (qb_valid),
    .q_cmd            (qb_cmd),
    .q_pop            (qb_pop),
    .screen_width     (screen_width_r),
    .screen_height    (screen_height_r),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_pixel_x      (out_pixel_x),
    .out_pixel_y      (out_pixel_y),
    .out_pixel_colour (out_pixel_colour),
    .out_visible      (out_visible),
    .out_last         (out_last)
  );

endmodule
